FILE: src/hvn_pkg.sv
// Package for the hashed value noise cloud cell classifier.
// Holds hash constants, register indexes, sample lane maps and the mix function.
// No dependencies.
package hvn_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned PROD_W   = 48;
    localparam int unsigned NUM_SAMP = 5;
    localparam int unsigned NUM_CRD  = 6;   // three x coordinates, then three z coordinates

    localparam logic [31:0] HASH_X    = 32'd374761393;
    localparam logic [31:0] HASH_Z    = 32'd668265263;
    localparam logic [31:0] HASH_SEED = 32'd362437;
    localparam logic [31:0] HASH_MUL  = 32'd1274126177;
    localparam logic [23:0] MASK24    = 24'hFFFFFF;

    localparam logic [31:0] SEED_RST     = 32'd0;
    localparam logic [31:0] INV_RST      = 32'd65536;
    localparam logic [23:0] COVERAGE_RST = 24'd8388608;

    typedef enum logic [1:0] {
        REG_SEED      = 2'd0,
        REG_INV_SCALE = 2'd1,
        REG_COVERAGE  = 2'd2
    } t_reg_idx;

    // Coordinate lane used by each sample on the x axis (0 = c, 1 = c+1, 2 = c-1).
    // Samples: centre, east, west, south, north.
    function automatic logic [1:0] samp_x(input int unsigned k);
        logic [1:0] r;
        case (k)
            1:       r = 2'd1;
            2:       r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] samp_z(input int unsigned k);
        logic [1:0] r;
        case (k)
            3:       r = 2'd1;
            4:       r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Linear blend in Q0.24: (a*(1-w) + b*w) >> 24
    function automatic logic [23:0] mix24(input logic [23:0] a, input logic [23:0] b,
                                          input logic [23:0] w);
        logic [24:0] wi;
        logic [49:0] acc;
        wi  = 25'h1000000 - {1'b0, w};
        acc = ({26'd0, a} * {25'd0, wi}) + ({26'd0, b} * {26'd0, w});
        return acc[47:24];
    endfunction

endpackage

FILE: src/hashed_value_noise_cloud_cell_classifier_top.sv
// Takes one cell per cycle while no result waits unaccepted.
// Seven register stages: coordinate multiply, neighbour offsets, hash/fraction
// products, hash sum and smoothstep weight, hash multiply, x mix, z mix, then an
// output register. The pipeline holds while a result waits unaccepted.
// Reset is synchronous, active low: clears valid bits, loads register defaults.
// Uses hvn_pkg.
module hashed_value_noise_cloud_cell_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_cell_x,
    input  logic [31:0] i_cell_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_cloud,
    output logic [23:0] o_noise_value,
    output logic [3:0]  o_face_mask
);

    logic [31:0] r_seed, r_inv_scale, r_seed_mul;
    logic [23:0] r_coverage;
    logic        adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= hvn_pkg::SEED_RST;
            r_inv_scale <= hvn_pkg::INV_RST;
            r_coverage  <= hvn_pkg::COVERAGE_RST;
        end else if (i_cfg_we) begin
            unique case (hvn_pkg::t_reg_idx'(i_cfg_idx))
                hvn_pkg::REG_SEED:      r_seed      <= i_cfg_data;
                hvn_pkg::REG_INV_SCALE: r_inv_scale <= i_cfg_data;
                hvn_pkg::REG_COVERAGE:  r_coverage  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Seed salt product, registered from the seed register
    always_ff @(posedge i_clk) begin
        r_seed_mul <= r_seed * hvn_pkg::HASH_SEED;
    end

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Valid chain
    logic [7:1] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_vld   <= {r_vld[6:1], i_valid};
            o_valid <= r_vld[7];
        end
    end

    // Stage 1: coordinate times reciprocal scale (low 48 bits of signed product)
    // Edge coordinates flagged: their +1 / -1 neighbour wraps at 32 bits
    logic signed [64:0] px_full, pz_full;
    logic [47:0] r1_px, r1_pz;
    logic        r1_xhi, r1_xlo, r1_zhi, r1_zlo;
    assign px_full = $signed(i_cell_x) * $signed({1'b0, r_inv_scale});
    assign pz_full = $signed(i_cell_z) * $signed({1'b0, r_inv_scale});
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_px  <= px_full[47:0];
            r1_pz  <= pz_full[47:0];
            r1_xhi <= (i_cell_x == 32'h7FFF_FFFF);
            r1_xlo <= (i_cell_x == 32'h8000_0000);
            r1_zhi <= (i_cell_z == 32'h7FFF_FFFF);
            r1_zlo <= (i_cell_z == 32'h8000_0000);
        end
    end

    // Stage 2: neighbour products as p +/- inv_scale, less 2^32 * inv_scale on a wrap at the top, plus it at the bottom
    logic [47:0] r2_p [hvn_pkg::NUM_CRD];
    logic [47:0] inv48;
    logic [47:0] wrap48;
    assign inv48  = {16'd0, r_inv_scale};
    assign wrap48 = {r_inv_scale[15:0], 32'd0};
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_p[0] <= r1_px;
            r2_p[1] <= r1_px + inv48 - (r1_xhi ? wrap48 : 48'd0);
            r2_p[2] <= r1_px - inv48 + (r1_xlo ? wrap48 : 48'd0);
            r2_p[3] <= r1_pz;
            r2_p[4] <= r1_pz + inv48 - (r1_zhi ? wrap48 : 48'd0);
            r2_p[5] <= r1_pz - inv48 + (r1_zlo ? wrap48 : 48'd0);
        end
    end

    // Stage 3: fraction square and index hash products
    logic [15:0] r3_f16 [hvn_pkg::NUM_CRD];
    logic [23:0] r3_f2  [hvn_pkg::NUM_CRD];
    logic [31:0] r3_hm  [hvn_pkg::NUM_CRD];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < hvn_pkg::NUM_CRD; c++) begin
                r3_f16[c] <= r2_p[c][15:0];
                r3_f2[c]  <= 24'(({16'd0, r2_p[c][15:0]} * {16'd0, r2_p[c][15:0]}) >> 8);
                r3_hm[c]  <= r2_p[c][47:16] * ((c < 3) ? hvn_pkg::HASH_X : hvn_pkg::HASH_Z);
            end
        end
    end

    // Stage 4: smoothstep weight and salted corner hash sum
    logic [23:0] r4_w  [hvn_pkg::NUM_CRD];
    logic [31:0] r4_hx [hvn_pkg::NUM_SAMP][4];
    logic [23:0] w_n   [hvn_pkg::NUM_CRD];
    logic [31:0] hx_n  [hvn_pkg::NUM_SAMP][4];
    always_comb begin
        logic [25:0] t;
        logic [49:0] s;
        logic [31:0] h;
        for (int c = 0; c < hvn_pkg::NUM_CRD; c++) begin
            t = 26'(3 * 26'h1000000) - {1'b0, r3_f16[c], 9'd0};
            s = {26'd0, r3_f2[c]} * {24'd0, t};
            w_n[c] = (s[49:24] > 26'(hvn_pkg::MASK24)) ? hvn_pkg::MASK24 : s[47:24];
        end
        for (int k = 0; k < hvn_pkg::NUM_SAMP; k++) begin
            for (int j = 0; j < 4; j++) begin
                h = r3_hm[hvn_pkg::samp_x(k)] + r3_hm[3 + hvn_pkg::samp_z(k)] + r_seed_mul
                    + (j[0] ? hvn_pkg::HASH_X : 32'd0) + (j[1] ? hvn_pkg::HASH_Z : 32'd0);
                hx_n[k][j] = h ^ (h >> 13);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_w  <= w_n;
            r4_hx <= hx_n;
        end
    end

    // Stage 5: hash multiply
    logic [23:0] r5_w [hvn_pkg::NUM_CRD];
    logic [31:0] r5_h [hvn_pkg::NUM_SAMP][4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_w <= r4_w;
            for (int k = 0; k < hvn_pkg::NUM_SAMP; k++)
                for (int j = 0; j < 4; j++)
                    r5_h[k][j] <= r4_hx[k][j] * hvn_pkg::HASH_MUL;
        end
    end

    // Stage 6: corner values, blend along x on both rows
    logic [23:0] r6_wz  [hvn_pkg::NUM_SAMP];
    logic [23:0] r6_row [hvn_pkg::NUM_SAMP][2];
    always_ff @(posedge i_clk) begin
        logic [23:0] v [4];
        logic [31:0] hh;
        if (adv) begin
            for (int k = 0; k < hvn_pkg::NUM_SAMP; k++) begin
                for (int j = 0; j < 4; j++) begin
                    hh   = r5_h[k][j] ^ (r5_h[k][j] >> 16);
                    v[j] = hh[23:0];
                end
                r6_row[k][0] <= hvn_pkg::mix24(v[0], v[1], r5_w[hvn_pkg::samp_x(k)]);
                r6_row[k][1] <= hvn_pkg::mix24(v[2], v[3], r5_w[hvn_pkg::samp_x(k)]);
                r6_wz[k]     <= r5_w[3 + hvn_pkg::samp_z(k)];
            end
        end
    end

    // Stage 7: blend along z
    logic [23:0] r7_n [hvn_pkg::NUM_SAMP];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < hvn_pkg::NUM_SAMP; k++)
                r7_n[k] <= hvn_pkg::mix24(r6_row[k][0], r6_row[k][1], r6_wz[k]);
        end
    end

    // Output register: threshold and exposed faces
    always_ff @(posedge i_clk) begin
        logic cloud;
        if (adv) begin
            cloud         = r7_n[0] > r_coverage;
            o_is_cloud    <= cloud;
            o_noise_value <= r7_n[0];
            for (int k = 1; k < hvn_pkg::NUM_SAMP; k++)
                o_face_mask[k-1] <= cloud && !(r7_n[k] > r_coverage);
        end
    end

endmodule

FILE: src/hvn_checker.sv
// Port checker for the cloud cell classifier, bound to the top level.
// Depends on hashed_value_noise_cloud_cell_classifier_top ports only.
module hvn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_is_cloud,
    input logic [23:0] o_noise_value,
    input logic [3:0]  o_face_mask
);

    // A stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value) && $stable(o_face_mask)
                                && $stable(o_is_cloud))
        else $error("result beat changed while stalled");

    // No exposed faces unless the cell is cloud
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_cloud |-> o_face_mask == 4'd0)
        else $error("face mask set on empty cell");

    // Input is taken whenever the output slot is free or draining
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output flow");

    // Reset empties the pipeline
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind hashed_value_noise_cloud_cell_classifier_top hvn_checker u_hvn_checker (.*);

FILE: dv/hashed_value_noise_cloud_cell_classifier_top_tb.sv
// Testbench for the hashed value noise cloud cell classifier.
// Predicts each result with an independent fixed-point noise model and checks beats in order.
// Depends on hvn_pkg and hashed_value_noise_cloud_cell_classifier_top.
module hashed_value_noise_cloud_cell_classifier_top_tb;

    localparam int unsigned WDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYC  = 20;

    typedef struct packed {
        logic        cloud;
        logic [23:0] noise;
        logic [3:0]  faces;
    } t_cell_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_cell_x;
    logic [31:0] i_cell_z;
    logic        o_valid;
    logic        i_ready;
    logic        o_is_cloud;
    logic [23:0] o_noise_value;
    logic [3:0]  o_face_mask;

    // Model copy of the registers
    logic [31:0] m_seed;
    logic [31:0] m_inv_scale;
    logic [23:0] m_coverage;

    t_cell_res   cell_res_q[$];
    int          fail_cnt;
    int          cells_sent;
    int          cells_checked;
    int          idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    hashed_value_noise_cloud_cell_classifier_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Salted lattice corner hash, low 24 bits
    function automatic logic [23:0] corner_val(logic [31:0] xi, logic [31:0] zi);
        logic [31:0] h;
        h = xi * hvn_pkg::HASH_X + zi * hvn_pkg::HASH_Z + m_seed * hvn_pkg::HASH_SEED;
        h = (h ^ (h >> 13)) * hvn_pkg::HASH_MUL;
        h = h ^ (h >> 16);
        return h[23:0];
    endfunction

    // Lattice index and smoothstep weight for one coordinate
    function automatic void split_coord(input logic [31:0] c, output logic [31:0] idx,
                                        output logic [23:0] wgt);
        logic signed [63:0] prod;
        logic [63:0]        f;
        logic [63:0]        f2;
        logic [63:0]        s;
        prod = $signed(c) * $signed({32'd0, m_inv_scale});
        f    = {40'd0, prod[15:0], 8'd0};
        f2   = (f * f) >> 24;
        s    = (f2 * (64'd3 * 64'h1000000 - 64'd2 * f)) >> 24;
        if (s > 64'hFFFFFF) s = 64'hFFFFFF;
        idx  = prod[47:16];
        wgt  = s[23:0];
    endfunction

    function automatic logic [23:0] blend(logic [23:0] a, logic [23:0] b, logic [23:0] w);
        logic [63:0] r;
        r = 64'(a) * (64'h1000000 - 64'(w)) + 64'(b) * 64'(w);
        return r[47:24];
    endfunction

    function automatic logic [23:0] noise_of(logic [31:0] cx, logic [31:0] cz);
        logic [31:0] xi;
        logic [31:0] zi;
        logic [23:0] wx;
        logic [23:0] wz;
        split_coord(cx, xi, wx);
        split_coord(cz, zi, wz);
        return blend(blend(corner_val(xi, zi), corner_val(xi + 1, zi), wx),
                     blend(corner_val(xi, zi + 1), corner_val(xi + 1, zi + 1), wx), wz);
    endfunction

    function automatic t_cell_res classify_cell(logic [31:0] cx, logic [31:0] cz);
        t_cell_res r;
        r.noise = noise_of(cx, cz);
        r.cloud = r.noise > m_coverage;
        r.faces = '0;
        if (r.cloud) begin
            r.faces[0] = !(noise_of(cx + 1, cz) > m_coverage);
            r.faces[1] = !(noise_of(cx - 1, cz) > m_coverage);
            r.faces[2] = !(noise_of(cx, cz + 1) > m_coverage);
            r.faces[3] = !(noise_of(cx, cz - 1) > m_coverage);
        end
        return r;
    endfunction

    // Register write, only while idle
    task automatic write_reg(input hvn_pkg::t_reg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            hvn_pkg::REG_SEED:      m_seed      = val;
            hvn_pkg::REG_INV_SCALE: m_inv_scale = val;
            default:                m_coverage  = val[23:0];
        endcase
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (cell_res_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    // Send one cell beat; valid held until accepted
    task automatic send_cell(input logic [31:0] cx, input logic [31:0] cz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cell_x <= cx;
        i_cell_z <= cz;
        cell_res_q = {cell_res_q, classify_cell(cx, cz)};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        cells_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(64)) - 32);
            2:       return 32'h8000_0000 + 32'($signed($urandom_range(8)) - 4);
            default: return 32'h7FFF_FFF0 + $urandom_range(31);
        endcase
    endfunction

    task automatic test_directed();
        send_cell(32'd0, 32'd0);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cell(32'h8000_0000, 32'h8000_0000);
        send_cell(32'hFFFF_FFFF, 32'd1);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000);
        send_cell(32'h8000_0000, 32'h7FFF_FFFF);
        send_cell(32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();
        // Full-scale scale: lattice index wraps
        write_reg(hvn_pkg::REG_INV_SCALE, 32'hFFFF_FFFF);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000);
        send_cell(32'hFFFF_FFFF, 32'h0000_0001);
        send_cell(32'h1234_5678, 32'h8765_4321);
        wait_drained();
        // Zero scale: every sample sits on corner (0,0)
        write_reg(hvn_pkg::REG_INV_SCALE, 32'd0);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000);
        send_cell(32'd5, 32'hFFFF_FFF9);
        wait_drained();
        // Smallest scale and extreme seed
        write_reg(hvn_pkg::REG_INV_SCALE, 32'd1);
        write_reg(hvn_pkg::REG_SEED, 32'hFFFF_FFFF);
        send_cell(32'h8000_0000, 32'h7FFF_FFFF);
        send_cell(32'd3, 32'hFFFF_FFFD);
        wait_drained();
        // Coverage extremes: everything cloud, then nothing
        write_reg(hvn_pkg::REG_COVERAGE, 32'd0);
        send_cell(32'd10, 32'd20);
        send_cell(32'hFFFF_FFF0, 32'd7);
        wait_drained();
        write_reg(hvn_pkg::REG_COVERAGE, 32'h00FF_FFFF);
        send_cell(32'd10, 32'd20);
        wait_drained();
        // Fractional scale and a low threshold, to get partial face masks
        write_reg(hvn_pkg::REG_INV_SCALE, 32'h0000_4000);
        write_reg(hvn_pkg::REG_COVERAGE, 32'h0040_0000);
        write_reg(hvn_pkg::REG_SEED, 32'hDEAD_BEEF);
        for (int i = 0; i < 6; i++) send_cell(32'(i * 3), 32'(i * 5 - 7));
        wait_drained();
    endtask

    task automatic test_random(input int n_cells);
        int unsigned scale_pick;
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_reg(hvn_pkg::REG_SEED, $urandom());
            scale_pick = $urandom_range(3);
            write_reg(hvn_pkg::REG_INV_SCALE, scale_pick == 0 ? $urandom() :
                      scale_pick == 1 ? $urandom_range(32'h0002_0000, 1) :
                      scale_pick == 2 ? 32'h0001_0000 : 32'hFFFF_FFFF);
            write_reg(hvn_pkg::REG_COVERAGE, $urandom_range(24'hFFFFFF));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int i = 0; i < n_cells / 8; i++) begin
                send_cell(rand_coord(), rand_coord());
                // Once per phase, hold off until the pipeline empties
                if (i == 20) wait_drained();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver stall, changed at the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checking at the rising edge
    always @(posedge i_clk) begin
        t_cell_res exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (cell_res_q.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                exp_r = cell_res_q.pop_front();
                cells_checked++;
                if (o_is_cloud !== exp_r.cloud) begin
                    $error("is_cloud: expected %0d actual %0d", exp_r.cloud, o_is_cloud);
                    fail_cnt++;
                end
                if (o_noise_value !== exp_r.noise) begin
                    $error("noise_value: expected %0h actual %0h", exp_r.noise, o_noise_value);
                    fail_cnt++;
                end
                if (o_face_mask !== exp_r.faces) begin
                    $error("face_mask: expected %0h actual %0h", exp_r.faces, o_face_mask);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        fail_cnt       = 0;
        cells_sent     = 0;
        cells_checked  = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        m_seed         = hvn_pkg::SEED_RST;
        m_inv_scale    = hvn_pkg::INV_RST;
        m_coverage     = hvn_pkg::COVERAGE_RST;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = hvn_pkg::REG_SEED;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_cell_x       = '0;
        i_cell_z       = '0;
        i_ready        = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1040);
        wait_drained();
        $display("Sent %0d cells, checked %0d results over scale, seed and coverage sweeps",
                 cells_sent, cells_checked);
        $display("with idle and stall phases on both channels.");
        if (fail_cnt == 0 && cell_res_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
